### rtl/bmi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bmi_pkg;

    // Default map size.
    localparam int COLUMNS_DEF = 12;
    localparam int ROWS_DEF    = 6;

    // Fraction format and cell read count.
    localparam int FRAC_W      = 16;
    localparam int CORNERS     = 4;

    // Operation codes carried by the opcode field.
    typedef enum logic [1:0] {
        OP_QUERY   = 2'd0,
        OP_WR_COL  = 2'd1,
        OP_WR_ROW  = 2'd2,
        OP_WR_CELL = 2'd3
    } opcode_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic write;
        logic load;
        logic scan;
        logic resolve;
        logic div_load;
        logic div_sel_y;
        logic div_step;
        logic fetch;
        logic blend;
        logic emit;
    } bmi_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic scan_done;
        logic div_done;
        logic fetch_done;
        logic blend_done;
    } bmi_stat_t;

endpackage

`default_nettype wire

### rtl/bmi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bmi_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [1:0]        opcode,
    input  wire bmi_pkg::bmi_stat_t stat,
    output bmi_pkg::bmi_cmd_t      cmd,
    output logic                   busy
);
    import bmi_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE    = 9'b000000001,
        ST_SCAN    = 9'b000000010,
        ST_RESOLVE = 9'b000000100,
        ST_LDX     = 9'b000001000,
        ST_DIVX    = 9'b000010000,
        ST_LDY     = 9'b000100000,
        ST_DIVY    = 9'b001000000,
        ST_FETCH   = 9'b010000000,
        ST_BLEND   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   is_query;

    assign is_query = (opcode == OP_QUERY);
    assign busy     = (state_reg != ST_IDLE);

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    if (is_query)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        cmd.write = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = ST_RESOLVE;
                end
            end
            ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = ST_LDX;
            end
            ST_LDX:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIVX;
            end
            ST_DIVX:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_LDY;
                end
            end
            ST_LDY:
            begin
                cmd.div_load  = 1'b1;
                cmd.div_sel_y = 1'b1;
                state_next    = ST_DIVY;
            end
            ST_DIVY:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    state_next = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                cmd.fetch = 1'b1;
                if (stat.fetch_done)
                begin
                    state_next = ST_BLEND;
                end
            end
            ST_BLEND:
            begin
                cmd.blend = 1'b1;
                if (stat.blend_done)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // A query beat always starts the axis scan.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && start && is_query) |=> (state_reg == ST_SCAN))
        else $error("query beat did not start the scan");

    // The result strobe closes the query and frees the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE))
        else $error("block stayed busy after the result");

    // Writes are only taken while no query is in flight.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.write || cmd.load) |-> !busy)
        else $error("beat taken while busy");

endmodule

`default_nettype wire

### rtl/bmi_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bmi_dp #(
    parameter int COLUMNS = bmi_pkg::COLUMNS_DEF,
    parameter int ROWS    = bmi_pkg::ROWS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire bmi_pkg::bmi_cmd_t  cmd,
    output bmi_pkg::bmi_stat_t      stat,
    input  wire logic [1:0]         opcode,
    input  wire logic [6:0]         entry_index,
    input  wire logic signed [15:0] entry_value,
    input  wire logic signed [15:0] query_column,
    input  wire logic signed [15:0] query_row,
    output logic [7:0]              map_value,
    output logic                    done
);
    import bmi_pkg::*;

    localparam int CAW      = $clog2(COLUMNS);
    localparam int RAW      = $clog2(ROWS);
    localparam int CELLS    = COLUMNS * ROWS;
    localparam int GAW      = $clog2(CELLS);
    localparam int SCAN_LEN = (COLUMNS > ROWS) ? COLUMNS : ROWS;
    localparam int SW       = $clog2(SCAN_LEN + 1);

    // Storage.
    logic signed [15:0] col_mem [COLUMNS];
    logic signed [15:0] row_mem [ROWS];
    logic [7:0]         cell_mem [CELLS];

    logic [31:0]        idx32;
    logic               col_we;
    logic               row_we;
    logic               cell_we;
    logic [CAW-1:0]     col_raddr;
    logic [RAW-1:0]     row_raddr;
    logic [GAW-1:0]     cell_raddr;
    logic signed [15:0] col_rd_reg;
    logic signed [15:0] row_rd_reg;
    logic [7:0]         cell_rd_reg;

    // Query and scan state.
    logic signed [15:0] qc_reg;
    logic signed [15:0] qr_reg;
    logic [SW-1:0]      scan_cnt_reg;
    logic               col_vld_reg;
    logic               row_vld_reg;
    logic [CAW-1:0]     col_idx_reg;
    logic [RAW-1:0]     row_idx_reg;

    logic               cfound_reg;
    logic signed [15:0] c_b1_reg;
    logic signed [15:0] c_b2_reg;
    logic signed [15:0] c_prev_reg;
    logic signed [15:0] c_first_reg;
    logic signed [15:0] c_last_reg;
    logic [CAW-1:0]     dx1_reg;
    logic [CAW-1:0]     dx2_reg;

    logic               rfound_reg;
    logic signed [15:0] r_b1_reg;
    logic signed [15:0] r_b2_reg;
    logic signed [15:0] r_prev_reg;
    logic signed [15:0] r_top_reg;
    logic signed [15:0] r_bot_reg;
    logic [RAW-1:0]     dy1_reg;
    logic [RAW-1:0]     dy2_reg;

    // Divider state.
    logic [16:0]        rem_reg;
    logic [16:0]        den_reg;
    logic [15:0]        quo_reg;
    logic [4:0]         dcnt_reg;
    logic               spz_reg;
    logic               spm_reg;
    logic               sel_y_reg;
    logic [15:0]        fx_reg;
    logic [15:0]        fy_reg;

    // Fetch and blend state.
    logic [2:0]         fetch_cnt_reg;
    logic [7:0]         v_reg [CORNERS];
    logic [2:0]         blend_cnt_reg;
    logic signed [42:0] prod_reg;
    logic signed [25:0] r1_reg;
    logic signed [25:0] r2_reg;
    logic [7:0]         map_value_reg;
    logic               done_reg;

    assign map_value = map_value_reg;
    assign done      = done_reg;

    // Write decode with range checks on the index.
    assign idx32   = {25'd0, entry_index};
    assign col_we  = cmd.write && (opcode == OP_WR_COL) && (idx32 < 32'(COLUMNS));
    assign row_we  = cmd.write && (opcode == OP_WR_ROW) && (idx32 < 32'(ROWS));
    assign cell_we = cmd.write && (opcode == OP_WR_CELL) && (idx32 < 32'(CELLS));

    // Column axis ascends from index 0, row axis is scanned from the last index down.
    assign col_raddr = scan_cnt_reg[CAW-1:0];
    assign row_raddr = RAW'(32'(ROWS - 1) - 32'(scan_cnt_reg));

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_mem[idx32[CAW-1:0]] <= entry_value;
        end
        col_rd_reg <= col_mem[col_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_mem[idx32[RAW-1:0]] <= entry_value;
        end
        row_rd_reg <= row_mem[row_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
        begin
            cell_mem[idx32[GAW-1:0]] <= entry_value[7:0];
        end
        cell_rd_reg <= cell_mem[cell_raddr];
    end

    // Scan sequencing: one breakpoint of each axis per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_cnt_reg <= '0;
            col_vld_reg  <= 1'b0;
            row_vld_reg  <= 1'b0;
        end
        else
        begin
            col_vld_reg <= cmd.scan && (32'(scan_cnt_reg) < 32'(COLUMNS));
            row_vld_reg <= cmd.scan && (32'(scan_cnt_reg) < 32'(ROWS));
            if (cmd.load)
            begin
                scan_cnt_reg <= '0;
            end
            else if (cmd.scan && (32'(scan_cnt_reg) < 32'(SCAN_LEN)))
            begin
                scan_cnt_reg <= scan_cnt_reg + 1'b1;
            end
        end
    end

    assign stat.scan_done = cmd.scan && (32'(scan_cnt_reg) == 32'(SCAN_LEN));

    // Index tags travel with the read data.
    always_ff @(posedge clk)
    begin
        col_idx_reg <= col_raddr;
        row_idx_reg <= row_raddr;
    end

    // Column bracket search: first breakpoint above the query.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfound_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            cfound_reg <= 1'b0;
        end
        else if (col_vld_reg && !cfound_reg && (col_rd_reg > qc_reg))
        begin
            cfound_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            qc_reg <= query_column;
            qr_reg <= query_row;
        end
        if (col_vld_reg)
        begin
            c_prev_reg <= col_rd_reg;
            if (col_idx_reg == '0)
            begin
                c_first_reg <= col_rd_reg;
            end
            if (col_idx_reg == CAW'(COLUMNS - 1))
            begin
                c_last_reg <= col_rd_reg;
            end
            if (!cfound_reg && (col_rd_reg > qc_reg))
            begin
                dx2_reg  <= col_idx_reg;
                c_b2_reg <= col_rd_reg;
                if (col_idx_reg == '0)
                begin
                    dx1_reg  <= col_idx_reg;
                    c_b1_reg <= col_rd_reg;
                end
                else
                begin
                    dx1_reg  <= col_idx_reg - 1'b1;
                    c_b1_reg <= c_prev_reg;
                end
            end
        end
        else if (cmd.resolve && !cfound_reg)
        begin
            // Query beyond the last breakpoint: both corners on the last column.
            dx1_reg  <= CAW'(COLUMNS - 1);
            dx2_reg  <= CAW'(COLUMNS - 1);
            c_b1_reg <= c_last_reg;
            c_b2_reg <= c_last_reg;
        end
    end

    // Row bracket search, scanned from the last row toward row zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rfound_reg <= 1'b0;
        end
        else if (cmd.load)
        begin
            rfound_reg <= 1'b0;
        end
        else if (row_vld_reg && !rfound_reg && (row_rd_reg > qr_reg))
        begin
            rfound_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_vld_reg)
        begin
            r_prev_reg <= row_rd_reg;
            if (row_idx_reg == '0)
            begin
                r_top_reg <= row_rd_reg;
            end
            if (row_idx_reg == RAW'(ROWS - 1))
            begin
                r_bot_reg <= row_rd_reg;
            end
            if (!rfound_reg && (row_rd_reg > qr_reg))
            begin
                dy2_reg  <= row_idx_reg;
                r_b2_reg <= row_rd_reg;
                if (row_idx_reg == RAW'(ROWS - 1))
                begin
                    dy1_reg  <= row_idx_reg;
                    r_b1_reg <= row_rd_reg;
                end
                else
                begin
                    dy1_reg  <= row_idx_reg + 1'b1;
                    r_b1_reg <= r_prev_reg;
                end
            end
        end
        else if (cmd.resolve && !rfound_reg)
        begin
            // No breakpoint above the query: both corners on row zero.
            dy1_reg  <= '0;
            dy2_reg  <= '0;
            r_b1_reg <= r_top_reg;
            r_b2_reg <= r_top_reg;
        end
    end

    // Clamp the coordinates and form numerator and denominator.
    logic signed [15:0] x_clamp;
    logic signed [15:0] y_clamp;
    logic signed [16:0] nx;
    logic signed [16:0] dxd;
    logic signed [16:0] ny;
    logic signed [16:0] dyd;
    logic signed [16:0] num_sel;
    logic signed [16:0] den_sel;

    always_comb
    begin
        if (qc_reg < c_first_reg)
        begin
            x_clamp = c_first_reg;
        end
        else if (qc_reg > c_last_reg)
        begin
            x_clamp = c_last_reg;
        end
        else
        begin
            x_clamp = qc_reg;
        end

        if (qr_reg < r_bot_reg)
        begin
            y_clamp = r_bot_reg;
        end
        else if (qr_reg > r_top_reg)
        begin
            y_clamp = r_top_reg;
        end
        else
        begin
            y_clamp = qr_reg;
        end
    end

    assign nx      = $signed({x_clamp[15], x_clamp}) - $signed({c_b1_reg[15], c_b1_reg});
    assign dxd     = $signed({c_b2_reg[15], c_b2_reg}) - $signed({c_b1_reg[15], c_b1_reg});
    assign ny      = $signed({y_clamp[15], y_clamp}) - $signed({r_b1_reg[15], r_b1_reg});
    assign dyd     = $signed({r_b2_reg[15], r_b2_reg}) - $signed({r_b1_reg[15], r_b1_reg});
    assign num_sel = cmd.div_sel_y ? ny : nx;
    assign den_sel = cmd.div_sel_y ? dyd : dxd;

    // Restoring divider, one quotient bit per cycle.
    logic [17:0] rem_sh;
    logic [17:0] rem_sub;
    logic        quo_bit;
    logic [15:0] quo_new;
    logic [15:0] frac_out;

    assign rem_sh   = {rem_reg, 1'b0};
    assign rem_sub  = rem_sh - {1'b0, den_reg};
    assign quo_bit  = (rem_sh >= {1'b0, den_reg});
    assign quo_new  = {quo_reg[14:0], quo_bit};
    assign frac_out = spz_reg ? 16'd0 : (spm_reg ? 16'hFFFF : quo_new);

    assign stat.div_done = cmd.div_step && (dcnt_reg == 5'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dcnt_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            dcnt_reg <= 5'(FRAC_W);
        end
        else if (cmd.div_step && (dcnt_reg != '0))
        begin
            dcnt_reg <= dcnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            rem_reg   <= num_sel;
            den_reg   <= den_sel;
            quo_reg   <= '0;
            sel_y_reg <= cmd.div_sel_y;
            spz_reg   <= (den_sel <= 17'sd0) || (num_sel <= 17'sd0);
            spm_reg   <= (num_sel >= den_sel);
        end
        else if (cmd.div_step)
        begin
            rem_reg <= quo_bit ? rem_sub[16:0] : rem_sh[16:0];
            quo_reg <= quo_new;
            if (dcnt_reg == 5'd1)
            begin
                if (sel_y_reg)
                begin
                    fy_reg <= frac_out;
                end
                else
                begin
                    fx_reg <= frac_out;
                end
            end
        end
    end

    // Corner fetch: v11, v12, v21, v22 in that order.
    logic [31:0] base1;
    logic [31:0] base2;

    assign base1 = 32'(dy1_reg) * 32'(COLUMNS);
    assign base2 = 32'(dy2_reg) * 32'(COLUMNS);

    always_comb
    begin
        unique case (fetch_cnt_reg[1:0])
            2'd0:    cell_raddr = GAW'(base1 + 32'(dx1_reg));
            2'd1:    cell_raddr = GAW'(base1 + 32'(dx2_reg));
            2'd2:    cell_raddr = GAW'(base2 + 32'(dx1_reg));
            default: cell_raddr = GAW'(base2 + 32'(dx2_reg));
        endcase
    end

    assign stat.fetch_done = cmd.fetch && (fetch_cnt_reg == 3'(CORNERS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fetch_cnt_reg <= '0;
        end
        else if (cmd.load)
        begin
            fetch_cnt_reg <= '0;
        end
        else if (cmd.fetch && (fetch_cnt_reg != 3'(CORNERS)))
        begin
            fetch_cnt_reg <= fetch_cnt_reg + 1'b1;
        end
    end

    logic [1:0] fetch_slot;
    assign fetch_slot = 2'(fetch_cnt_reg - 1'b1);

    always_ff @(posedge clk)
    begin
        if (cmd.fetch && (fetch_cnt_reg != '0))
        begin
            v_reg[fetch_slot] <= cell_rd_reg;
        end
    end

    // Blend: one shared multiplier, its product registered each step.
    logic signed [8:0]  d_lo;
    logic signed [8:0]  d_hi;
    logic signed [25:0] d_r;
    logic signed [25:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [43:0] res;
    logic [43:0]        res_rnd;

    assign d_lo = $signed({1'b0, v_reg[2]}) - $signed({1'b0, v_reg[0]});
    assign d_hi = $signed({1'b0, v_reg[3]}) - $signed({1'b0, v_reg[1]});
    assign d_r  = r2_reg - r1_reg;

    always_comb
    begin
        unique case (blend_cnt_reg)
            3'd0:
            begin
                mul_a = {{17{d_lo[8]}}, d_lo};
                mul_b = $signed({1'b0, fy_reg});
            end
            3'd1:
            begin
                mul_a = {{17{d_hi[8]}}, d_hi};
                mul_b = $signed({1'b0, fy_reg});
            end
            default:
            begin
                mul_a = d_r;
                mul_b = $signed({1'b0, fx_reg});
            end
        endcase
    end

    assign res     = $signed({{2{r1_reg[25]}}, r1_reg, 16'd0}) + $signed({prod_reg[42], prod_reg});
    assign res_rnd = res + 44'h0_8000_0000;

    assign stat.blend_done = cmd.blend && (blend_cnt_reg == 3'd4);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
            if (cmd.load)
            begin
                blend_cnt_reg <= '0;
            end
            else if (cmd.blend && (blend_cnt_reg != 3'd4))
            begin
                blend_cnt_reg <= blend_cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.blend)
        begin
            prod_reg <= mul_a * mul_b;
            if (blend_cnt_reg == 3'd1)
            begin
                r1_reg <= $signed({2'b00, v_reg[0], 16'd0}) + prod_reg[25:0];
            end
            if (blend_cnt_reg == 3'd2)
            begin
                r2_reg <= $signed({2'b00, v_reg[1], 16'd0}) + prod_reg[25:0];
            end
        end
        if (cmd.emit)
        begin
            // Round half up; a negative blend reads as zero.
            map_value_reg <= res[43] ? 8'd0 : res_rnd[39:32];
        end
    end

endmodule

`default_nettype wire

### rtl/bilinear_map_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none

// A query returns map_value together with a done strobe; busy is high while the query is in
// flight. A new query is taken only when the block is idle; the axis scan, two 16-step
// divisions, four cell reads and a five-step blend share one controller. Writes produce no
// result and leave the controller idle.
// done is a single-cycle strobe with no stall; the receiver must take it when it appears.
// Reset: rst_n clears the controller and strobes; axis and cell stores hold no reset value.
module bilinear_map_interpolator #(
    parameter int COLUMNS = bmi_pkg::COLUMNS_DEF,
    parameter int ROWS    = bmi_pkg::ROWS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         opcode,
    input  wire logic [6:0]         entry_index,
    input  wire logic signed [15:0] entry_value,
    input  wire logic signed [15:0] query_column,
    input  wire logic signed [15:0] query_row,
    output logic [7:0]              map_value,
    output logic                    done
);
    import bmi_pkg::*;

    bmi_cmd_t  cmd;
    bmi_stat_t stat;

    // Sequencer.
    bmi_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .opcode (opcode),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy)
    );

    // Stores, search, divider and blend.
    bmi_dp #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .entry_index  (entry_index),
        .entry_value  (entry_value),
        .query_column (query_column),
        .query_row    (query_row),
        .map_value    (map_value),
        .done         (done)
    );

endmodule

`default_nettype wire
